@@ rtl/assert_macros.svh @@
// Assertion helpers; clock and reset are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LSBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define LSBP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define LSBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lsbp_pkg.sv @@
`timescale 1ns / 1ps

package lsbp_pkg;

   localparam int MAX_FIELD_BITS_DEF = 64;

   localparam int VALUE_W   = 64;
   localparam int COUNT_W   = 7;
   localparam int BYTE_W    = 8;
   localparam int BBITS_W   = 4;
   localparam int TOTAL_W   = 32;
   localparam int FILL_W    = 3;
   localparam int PEND_W    = 7;
   localparam int WORD_W    = VALUE_W + BYTE_W;
   localparam int LEFT_W    = 4;
   localparam int TOT_ACC_W = TOTAL_W + 1;

   typedef enum logic {
      CMD_APPEND = 1'b0,
      CMD_FLUSH  = 1'b1
   } lsbp_cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0]    data;
      logic [BBITS_W-1:0]   last_bits;
      logic [TOT_ACC_W-1:0] tot;
   } lsbp_work_type;

   typedef struct packed {
      logic               valid;
      logic [LEFT_W-1:0]  left;
      lsbp_work_type      work;
   } lsbp_load_type;

   function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOT_ACC_W-1:0] x);
      sat_total = x[TOTAL_W] ? {TOTAL_W{1'b1}} : x[TOTAL_W-1:0];
   endfunction

endpackage

@@ rtl/lsbp_if.sv @@
`timescale 1ns / 1ps

interface lsbp_req_if
   import lsbp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [VALUE_W-1:0] field_value;
   logic [COUNT_W-1:0] bit_count;

   modport source (output valid, cmd, field_value, bit_count, input ready);
   modport sink   (input valid, cmd, field_value, bit_count, output ready);
endinterface

interface lsbp_rsp_if
   import lsbp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  byte_data;
   logic [BBITS_W-1:0] byte_bits;
   logic               last_in_run;
   logic [TOTAL_W-1:0] total_bits;

   modport source (output valid, byte_data, byte_bits, last_in_run, total_bits, input ready);
   modport sink   (input valid, byte_data, byte_bits, last_in_run, total_bits, output ready);
endinterface

@@ rtl/lsbp_front.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsbp_front
   import lsbp_pkg::*;
#(
   parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   lsbp_req_if.sink      req,
   input  logic          can_take,
   output lsbp_load_type load
);

   logic [PEND_W-1:0]  pend_ff,  pend_in;
   logic [FILL_W-1:0]  fill_ff,  fill_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic                 accept;
   logic                 flush;
   logic [COUNT_W-1:0]   cnt;
   logic [VALUE_W-1:0]   val;
   logic [COUNT_W:0]     combined;
   logic [LEFT_W-1:0]    nbytes;
   logic [WORD_W-1:0]    word;
   logic [WORD_W-1:0]    word_sh;
   logic [TOT_ACC_W-1:0] sum;
   logic [TOTAL_W-1:0]   base;

   assign req.ready = can_take;
   assign accept    = req.valid && can_take;
   assign flush     = (req.cmd == CMD_FLUSH);

   always_comb begin
      cnt      = (req.bit_count > COUNT_W'(MAX_FIELD_BITS)) ? COUNT_W'(MAX_FIELD_BITS)
                                                            : req.bit_count;
      val      = req.field_value & ~({VALUE_W{1'b1}} << cnt);
      combined = (COUNT_W+1)'(fill_ff) + (COUNT_W+1)'(cnt);
      nbytes   = combined[COUNT_W-1:FILL_W];
      word     = WORD_W'(pend_ff) | (WORD_W'(val) << fill_ff);
      word_sh  = word >> {nbytes, 3'b000};
      sum      = TOT_ACC_W'(total_ff) + TOT_ACC_W'(cnt);
      base     = (total_ff >= TOTAL_W'(fill_ff)) ? (total_ff - TOTAL_W'(fill_ff)) : '0;

      pend_in  = pend_ff;
      fill_in  = fill_ff;
      total_in = total_ff;

      load.valid          = accept;
      load.left           = nbytes;
      load.work.data      = word;
      load.work.last_bits = BBITS_W'(BYTE_W);
      load.work.tot       = TOT_ACC_W'(base) + TOT_ACC_W'(BYTE_W);

      if (flush) begin
         load.left           = (fill_ff != '0) ? LEFT_W'(1) : '0;
         load.work.data      = WORD_W'(pend_ff);
         load.work.last_bits = BBITS_W'(fill_ff);
         load.work.tot       = TOT_ACC_W'(total_ff);
      end

      if (accept) begin
         if (flush) begin
            pend_in  = '0;
            fill_in  = '0;
            total_in = '0;
         end else begin
            pend_in  = word_sh[PEND_W-1:0];
            fill_in  = combined[FILL_W-1:0];
            total_in = sat_total(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         fill_ff  <= '0;
         total_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   `LSBP_ASSERT(a_pend_clean, (pend_ff >> fill_ff) == '0, "pending bits above fill not zero")
   `LSBP_ASSERT_NEXT(a_flush_restart, accept && flush, fill_ff == '0 && total_ff == '0, "flush did not restart")
   `LSBP_ASSERT_NEXT(a_total_sticky, !reset && accept && !flush && total_ff == '1, total_ff == '1, "saturated total dropped")

endmodule

@@ rtl/lsbp_emit.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsbp_emit
   import lsbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lsbp_load_type load,
   output logic          can_take,
   lsbp_rsp_if.source    rsp
);

   logic [LEFT_W-1:0]  left_ff, left_in;
   lsbp_work_type      work_ff, work_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  data_ff,  data_in;
   logic [BBITS_W-1:0] bits_ff,  bits_in;
   logic               last_ff,  last_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic out_load;
   logic pop;

   always_comb begin
      out_load = !rsp_valid_ff || rsp.ready;
      pop      = out_load && (left_ff != '0);
      can_take = (left_ff == '0) || ((left_ff == LEFT_W'(1)) && pop);

      left_in = left_ff;
      work_in = work_ff;
      if (load.valid) begin
         left_in = load.left;
         work_in = load.work;
      end else if (pop) begin
         left_in      = left_ff - LEFT_W'(1);
         work_in.data = work_ff.data >> BYTE_W;
         work_in.tot  = work_ff.tot + TOT_ACC_W'(BYTE_W);
      end

      rsp_valid_in = rsp_valid_ff;
      data_in      = data_ff;
      bits_in      = bits_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      if (out_load) begin
         rsp_valid_in = (left_ff != '0);
         data_in      = work_ff.data[BYTE_W-1:0];
         last_in      = (left_ff == LEFT_W'(1));
         bits_in      = last_in ? work_ff.last_bits : BBITS_W'(BYTE_W);
         total_in     = sat_total(work_ff.tot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff  <= work_in;
      data_ff  <= data_in;
      bits_ff  <= bits_in;
      last_ff  <= last_in;
      total_ff <= total_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.byte_data   = data_ff;
   assign rsp.byte_bits   = bits_ff;
   assign rsp.last_in_run = last_ff;
   assign rsp.total_bits  = total_ff;

   `LSBP_ASSERT_IMPL(a_no_overwrite, load.valid, left_ff == '0 || (left_ff == LEFT_W'(1) && pop), "work overwritten")
   `LSBP_ASSERT(a_left_range, left_ff <= LEFT_W'(BYTE_W), "too many bytes queued")
   `LSBP_ASSERT_IMPL(a_partial_last, rsp_valid_ff && bits_ff != BBITS_W'(BYTE_W), last_ff, "partial byte not last")

endmodule

@@ rtl/lsb_first_bit_packer.sv @@
`timescale 1ns / 1ps
// Channel  Ports     Dir  Payload
// request  req_bus   in   cmd, field_value[63:0], bit_count[6:0]
// result   rsp_bus   out  byte_data[7:0], byte_bits[3:0], last_in_run, total_bits[31:0]
//
// The single byte output register drains the work register one byte per cycle while
// rsp_bus is not stalled. A transferred request goes into the work register, and its
// first byte then into the byte output register, before it appears on rsp_bus.
// Synchronous reset clears the bit position, total and all valid flags.
// A stall on rsp_bus holds the output byte and, once the work register is full,
// drops req_bus.ready.

module lsb_first_bit_packer
   import lsbp_pkg::*;
#(
   parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lsbp_req_if.sink   req_bus,
   lsbp_rsp_if.source rsp_bus
);

   lsbp_load_type load;
   logic          can_take;

   lsbp_front #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .can_take (can_take),
      .load     (load)
   );

   lsbp_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .can_take (can_take),
      .rsp      (rsp_bus)
   );

endmodule
